### rtl/roi_masked_point_operation_defines.svh
// Assertion macros for the region-masked point operation.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ROI_MASKED_POINT_OPERATION_DEFINES_SVH
`define ROI_MASKED_POINT_OPERATION_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMPO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RMPO_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define RMPO_ASSERT(lbl, clk, rstn, prop)
`define RMPO_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

### rtl/rmpo_pkg.sv
// Shared constants, codes and types of the region-masked point operation.
// Used by every module of the block; depends on nothing.
package rmpo_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SIZE_BITS     = COORD_BITS + 1;
  localparam int SPAN_BITS     = COORD_BITS + 2;
  localparam int PIX_BITS      = 8;
  localparam int THR_BITS      = 9;
  localparam int OFS_BITS      = 9;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = (SIZE_BITS > THR_BITS) ? SIZE_BITS : THR_BITS;

  localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_BITS-1:0] PIX_MIN = 8'd0;
  localparam logic [THR_BITS-1:0] THR_RESET = 9'd128;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_OP_MODE     = 3'd0,
    REG_THRESHOLD   = 3'd1,
    REG_GREY_OFFSET = 3'd2,
    REG_ROI_TOP     = 3'd3,
    REG_ROI_LEFT    = 3'd4,
    REG_ROI_HEIGHT  = 3'd5,
    REG_ROI_WIDTH   = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_BINARIZE = 1'b0,
    OP_ADD_GREY = 1'b1
  } op_mode_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] raw;
    logic [PIX_BITS-1:0] sat;
    logic                below;
  } lane_res_t;

endpackage

### rtl/rmpo_lane.sv
// One channel lane: saturating offset add and threshold compare, registered.
// Depends on rmpo_pkg.
module rmpo_lane (
  input  logic                            clk,
  input  logic [rmpo_pkg::PIX_BITS-1:0]   sample,
  input  logic [rmpo_pkg::THR_BITS-1:0]   threshold,
  input  logic signed [rmpo_pkg::OFS_BITS-1:0] offset,
  output rmpo_pkg::lane_res_t             res_r
);
  import rmpo_pkg::*;

  logic signed [PIX_BITS+1:0] sum;
  lane_res_t                  res_nxt;

  always_comb begin
    sum = $signed({2'b00, sample}) + {offset[OFS_BITS-1], offset};
    res_nxt.raw = sample;
    res_nxt.below = ({1'b0, sample} < threshold);
    priority if (sum[PIX_BITS+1]) begin
      res_nxt.sat = PIX_MIN;
    end else if (sum[PIX_BITS]) begin
      res_nxt.sat = PIX_MAX;
    end else begin
      res_nxt.sat = sum[PIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

### rtl/rmpo_region.sv
// Region test: row and column against the inclusive-exclusive bounds, registered.
// Depends on rmpo_pkg.
module rmpo_region (
  input  logic                             clk,
  input  logic [rmpo_pkg::COORD_BITS-1:0]  row,
  input  logic [rmpo_pkg::COORD_BITS-1:0]  col,
  input  logic [rmpo_pkg::COORD_BITS-1:0]  roi_top,
  input  logic [rmpo_pkg::COORD_BITS-1:0]  roi_left,
  input  logic [rmpo_pkg::SIZE_BITS-1:0]   roi_height,
  input  logic [rmpo_pkg::SIZE_BITS-1:0]   roi_width,
  output logic                             inside_r
);
  import rmpo_pkg::*;

  logic [SPAN_BITS-1:0] row_end;
  logic [SPAN_BITS-1:0] col_end;
  logic                 inside_nxt;

  always_comb begin
    row_end = {2'b00, roi_top} + {1'b0, roi_height};
    col_end = {2'b00, roi_left} + {1'b0, roi_width};
    inside_nxt = (row >= roi_top) && ({2'b00, row} < row_end) &&
                 (col >= roi_left) && ({2'b00, col} < col_end);
  end

  always_ff @(posedge clk) begin
    inside_r <= inside_nxt;
  end

endmodule

### rtl/roi_masked_point_operation.sv
// Throughput: one word per clock; start is registered through v1_r and then valid_r to out_valid.
// Stage 1 runs the region test and three channel lanes side by side,
// stage 2 merges lane results by mode and region into the output registers.
// busy stays low; results cannot be stalled by the receiver.
// Synchronous active-low reset clears the pipeline valids and the configuration registers.
`include "roi_masked_point_operation_defines.svh"
module roi_masked_point_operation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rmpo_pkg::COORD_BITS-1:0]      in_pixel_row,
  input  logic [rmpo_pkg::COORD_BITS-1:0]      in_pixel_col,
  input  logic [rmpo_pkg::PIX_BITS-1:0]        in_red,
  input  logic [rmpo_pkg::PIX_BITS-1:0]        in_green,
  input  logic [rmpo_pkg::PIX_BITS-1:0]        in_blue,
  input  logic                                 cfg_we,
  input  logic [rmpo_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [rmpo_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output logic                                 out_valid,
  output logic [rmpo_pkg::PIX_BITS-1:0]        out_red,
  output logic [rmpo_pkg::PIX_BITS-1:0]        out_green,
  output logic [rmpo_pkg::PIX_BITS-1:0]        out_blue,
  output logic                                 out_inside_region
);
  import rmpo_pkg::*;

  op_mode_t                    mode_r;
  logic [THR_BITS-1:0]         thr_r;
  logic signed [OFS_BITS-1:0]  ofs_r;
  logic [COORD_BITS-1:0]       top_r;
  logic [COORD_BITS-1:0]       left_r;
  logic [SIZE_BITS-1:0]        height_r;
  logic [SIZE_BITS-1:0]        width_r;

  logic                        accept;
  logic                        v1_r;
  op_mode_t                    m1_r;
  op_mode_t                    m2_r;
  logic                        inside1;
  lane_res_t                   lane_red;
  lane_res_t                   lane_green;
  lane_res_t                   lane_blue;

  logic                        valid_r;
  logic [PIX_BITS-1:0]         red_r;
  logic [PIX_BITS-1:0]         green_r;
  logic [PIX_BITS-1:0]         blue_r;
  logic                        inside_r;
  logic [PIX_BITS-1:0]         red_nxt;
  logic [PIX_BITS-1:0]         green_nxt;
  logic [PIX_BITS-1:0]         blue_nxt;
  logic [PIX_BITS-1:0]         level;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= OP_BINARIZE;
      thr_r    <= THR_RESET;
      ofs_r    <= '0;
      top_r    <= '0;
      left_r   <= '0;
      height_r <= '0;
      width_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_OP_MODE:     mode_r   <= op_mode_t'(cfg_wdata[0]);
        REG_THRESHOLD:   thr_r    <= cfg_wdata[THR_BITS-1:0];
        REG_GREY_OFFSET: ofs_r    <= cfg_wdata[OFS_BITS-1:0];
        REG_ROI_TOP:     top_r    <= cfg_wdata[COORD_BITS-1:0];
        REG_ROI_LEFT:    left_r   <= cfg_wdata[COORD_BITS-1:0];
        REG_ROI_HEIGHT:  height_r <= cfg_wdata[SIZE_BITS-1:0];
        REG_ROI_WIDTH:   width_r  <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  rmpo_region u_region (
    .clk        (clk),
    .row        (in_pixel_row),
    .col        (in_pixel_col),
    .roi_top    (top_r),
    .roi_left   (left_r),
    .roi_height (height_r),
    .roi_width  (width_r),
    .inside_r   (inside1)
  );

  rmpo_lane u_lane_red (
    .clk (clk), .sample (in_red), .threshold (thr_r), .offset (ofs_r), .res_r (lane_red)
  );

  rmpo_lane u_lane_green (
    .clk (clk), .sample (in_green), .threshold (thr_r), .offset (ofs_r), .res_r (lane_green)
  );

  rmpo_lane u_lane_blue (
    .clk (clk), .sample (in_blue), .threshold (thr_r), .offset (ofs_r), .res_r (lane_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      v1_r    <= accept;
      valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= mode_r;
    m2_r <= m1_r;
  end

  // merge: binarize follows channel 0 only
  always_comb begin
    level = lane_red.below ? PIX_MIN : PIX_MAX;
    priority if (!inside1) begin
      red_nxt   = lane_red.raw;
      green_nxt = lane_green.raw;
      blue_nxt  = lane_blue.raw;
    end else if (m1_r == OP_BINARIZE) begin
      red_nxt   = level;
      green_nxt = level;
      blue_nxt  = level;
    end else begin
      red_nxt   = lane_red.sat;
      green_nxt = lane_green.sat;
      blue_nxt  = lane_blue.sat;
    end
  end

  always_ff @(posedge clk) begin
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    inside_r <= inside1;
  end

  assign out_valid         = valid_r;
  assign out_red           = red_r;
  assign out_green         = green_r;
  assign out_blue          = blue_r;
  assign out_inside_region = inside_r;

  `RMPO_ASSERT(a_valid_follows_start, clk, rst_n, out_valid |-> $past(start, 2))
  `RMPO_ASSERT(a_outside_passes, clk, rst_n,
    (out_valid && !out_inside_region) |-> (out_red == $past(in_red, 2) &&
      out_green == $past(in_green, 2) && out_blue == $past(in_blue, 2)))
  `RMPO_ASSERT(a_binarize_grey, clk, rst_n,
    (out_valid && out_inside_region && m2_r == OP_BINARIZE) |->
      (out_red == out_green && out_green == out_blue &&
       (out_red == PIX_MIN || out_red == PIX_MAX)))
  `RMPO_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

### sim/roi_masked_point_operation_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for roi_masked_point_operation: directed pixel rows, then random
// pixels under changing region and mode settings, scored against the expected values of the
// directed table or an in-bench pixel predictor. Depends on rmpo_pkg and the roi_masked_point_operation RTL.
module roi_masked_point_operation_tb;
  import rmpo_pkg::*;

  localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES = 9;
  localparam int PHASE_WORDS = 206;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                in_roi;
  } pix_res_t;

  typedef struct packed {
    op_mode_t             mode;
    logic [THR_BITS-1:0]  thr;
    logic [OFS_BITS-1:0]  ofs;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] left;
    logic [SIZE_BITS-1:0] height;
    logic [SIZE_BITS-1:0] width;
  } roi_cfg_t;

  typedef struct {
    roi_cfg_t              cfg;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [PIX_BITS-1:0]   red;
    logic [PIX_BITS-1:0]   green;
    logic [PIX_BITS-1:0]   blue;
    bit                    typed;
    pix_res_t              res;
  } stim_row_t;

  localparam roi_cfg_t CFG_AT_RESET = '{mode: OP_BINARIZE, thr: THR_RESET, ofs: '0,
                                        top: '0, left: '0, height: '0, width: '0};

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [COORD_BITS-1:0] in_pixel_row;
  logic [COORD_BITS-1:0] in_pixel_col;
  logic [PIX_BITS-1:0] in_red;
  logic [PIX_BITS-1:0] in_green;
  logic [PIX_BITS-1:0] in_blue;
  logic cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic out_valid;
  logic [PIX_BITS-1:0] out_red;
  logic [PIX_BITS-1:0] out_green;
  logic [PIX_BITS-1:0] out_blue;
  logic out_inside_region;

  bit dir_typed;
  pix_res_t dir_res;
  roi_cfg_t reg_shadow;
  roi_cfg_t cur;
  pix_res_t pending_pixels[$];
  stim_row_t stim_rows[$];
  int n_errors = 0;
  int n_pixels = 0;
  int n_inside = 0;
  int n_settings = 0;

  roi_masked_point_operation i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel_row(in_pixel_row),
    .in_pixel_col(in_pixel_col),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_inside_region(out_inside_region)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [PIX_BITS-1:0] sat_add(logic [PIX_BITS-1:0] ch,
                                                  logic [OFS_BITS-1:0] ofs);
    int s;
    s = int'(ch) + int'($signed(ofs));
    if (s > 255) return PIX_MAX;
    if (s < 0) return PIX_MIN;
    return s[PIX_BITS-1:0];
  endfunction

  function automatic pix_res_t predict_pixel(roi_cfg_t c, logic [COORD_BITS-1:0] row,
                                             logic [COORD_BITS-1:0] col,
                                             logic [PIX_BITS-1:0] r, logic [PIX_BITS-1:0] g,
                                             logic [PIX_BITS-1:0] b);
    pix_res_t p;
    p.in_roi = int'(row) >= int'(c.top) && int'(row) < int'(c.top) + int'(c.height) &&
               int'(col) >= int'(c.left) && int'(col) < int'(c.left) + int'(c.width);
    p.red = r;
    p.green = g;
    p.blue = b;
    if (p.in_roi) begin
      if (c.mode == OP_BINARIZE) begin
        p.red = ({1'b0, r} < c.thr) ? PIX_MIN : PIX_MAX;
        p.green = p.red;
        p.blue = p.red;
      end else begin
        p.red = sat_add(r, c.ofs);
        p.green = sat_add(g, c.ofs);
        p.blue = sat_add(b, c.ofs);
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pix_res_t got;
    pix_res_t want;
    if (!rst_n) begin
      reg_shadow <= CFG_AT_RESET;
    end else begin
      if (out_valid) begin
        got = {out_red, out_green, out_blue, out_inside_region};
        if (pending_pixels.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word red=%0d green=%0d blue=%0d in_roi=%0b", $time,
                   got.red, got.green, got.blue, got.in_roi);
        end else begin
          want = pending_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.in_roi !== want.in_roi) begin
            n_errors++;
            $display("%0t: mismatch expected %0d/%0d/%0d in_roi=%0b, actual %0d/%0d/%0d in_roi=%0b",
                     $time, want.red, want.green, want.blue, want.in_roi,
                     got.red, got.green, got.blue, got.in_roi);
          end
          if (got.in_roi === 1'b1) n_inside++;
        end
      end
      if (start && !busy) begin
        n_pixels++;
        if (dir_typed) pending_pixels.push_back(dir_res);
        else pending_pixels.push_back(predict_pixel(reg_shadow, in_pixel_row, in_pixel_col,
                                                    in_red, in_green, in_blue));
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_OP_MODE: reg_shadow.mode <= op_mode_t'(cfg_wdata[0]);
          REG_THRESHOLD: reg_shadow.thr <= cfg_wdata[THR_BITS-1:0];
          REG_GREY_OFFSET: reg_shadow.ofs <= cfg_wdata[OFS_BITS-1:0];
          REG_ROI_TOP: reg_shadow.top <= cfg_wdata[COORD_BITS-1:0];
          REG_ROI_LEFT: reg_shadow.left <= cfg_wdata[COORD_BITS-1:0];
          REG_ROI_HEIGHT: reg_shadow.height <= cfg_wdata[SIZE_BITS-1:0];
          REG_ROI_WIDTH: reg_shadow.width <= cfg_wdata[SIZE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  function automatic roi_cfg_t mk_cfg(op_mode_t m, logic [THR_BITS-1:0] thr,
                                      logic [OFS_BITS-1:0] ofs, logic [COORD_BITS-1:0] top,
                                      logic [COORD_BITS-1:0] left,
                                      logic [SIZE_BITS-1:0] height,
                                      logic [SIZE_BITS-1:0] width);
    roi_cfg_t c;
    c.mode = m;
    c.thr = thr;
    c.ofs = ofs;
    c.top = top;
    c.left = left;
    c.height = height;
    c.width = width;
    return c;
  endfunction

  task automatic add_row(roi_cfg_t c, logic [COORD_BITS-1:0] row,
                         logic [COORD_BITS-1:0] col, logic [PIX_BITS-1:0] r,
                         logic [PIX_BITS-1:0] g, logic [PIX_BITS-1:0] b, bit typed,
                         pix_res_t res);
    stim_row_t s;
    s.cfg = c;
    s.row = row;
    s.col = col;
    s.red = r;
    s.green = g;
    s.blue = b;
    s.typed = typed;
    s.res = res;
    stim_rows.push_back(s);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = data;
  endtask

  // drain the pipeline, then reprogram every register
  task automatic program_raw(logic [CFG_DATA_BITS-1:0] op_raw,
                             logic [CFG_DATA_BITS-1:0] thr_raw,
                             logic [CFG_DATA_BITS-1:0] ofs_raw,
                             logic [CFG_DATA_BITS-1:0] top_raw,
                             logic [CFG_DATA_BITS-1:0] left_raw,
                             logic [CFG_DATA_BITS-1:0] h_raw,
                             logic [CFG_DATA_BITS-1:0] w_raw);
    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    write_reg(REG_OP_MODE, op_raw);
    write_reg(REG_THRESHOLD, thr_raw);
    write_reg(REG_GREY_OFFSET, ofs_raw);
    write_reg(REG_ROI_TOP, top_raw);
    write_reg(REG_ROI_LEFT, left_raw);
    write_reg(REG_ROI_HEIGHT, h_raw);
    write_reg(REG_ROI_WIDTH, w_raw);
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    @(negedge clk);
    cfg_we = 1'b0;
    cur = mk_cfg(op_mode_t'(op_raw[0]), thr_raw[THR_BITS-1:0], ofs_raw[OFS_BITS-1:0],
                 top_raw[COORD_BITS-1:0], left_raw[COORD_BITS-1:0], h_raw, w_raw);
    n_settings++;
  endtask

  task automatic send_word(logic [COORD_BITS-1:0] row, logic [COORD_BITS-1:0] col,
                           logic [PIX_BITS-1:0] r, logic [PIX_BITS-1:0] g,
                           logic [PIX_BITS-1:0] b, bit typed, pix_res_t res, int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_pixel_row = row;
    in_pixel_col = col;
    in_red = r;
    in_green = g;
    in_blue = b;
    dir_typed = typed;
    dir_res = res;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(int first, int count);
    int v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = first;
      2: v = first - 1;
      3: v = first + count - 1;
      4: v = first + count;
      default: v = first + $urandom_range(count > 0 ? count - 1 : 0);
    endcase
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [PIX_BITS-1:0] pick_chan();
    case ($urandom_range(3))
      0: return PIX_MIN;
      1: return PIX_MAX;
      default: return PIX_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_BITS-1:0] pick_red(int thr);
    int v;
    case ($urandom_range(3))
      0: v = thr - 1;
      1: v = thr;
      default: v = pick_chan();
    endcase
    return v[PIX_BITS-1:0];
  endfunction

  initial begin
    roi_cfg_t c_box, c_hi, c_zero, c_edge, c_neg, c_neg1, c_mid, c_empty;
    int pct;
    int idle_pct;
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_row = '0;
    in_pixel_col = '0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_OP_MODE;
    cfg_wdata = '0;
    dir_typed = 1'b0;
    dir_res = '0;
    cur = CFG_AT_RESET;

    c_box = mk_cfg(OP_BINARIZE, 9'd128, 9'd0, 12'd10, 12'd20, 13'd5, 13'd6);
    c_hi = mk_cfg(OP_BINARIZE, 9'd256, 9'd0, 12'd0, 12'd0, 13'd4096, 13'd4096);
    c_zero = mk_cfg(OP_BINARIZE, 9'd0, 9'd0, 12'd0, 12'd0, 13'd4096, 13'd4096);
    c_edge = mk_cfg(OP_ADD_GREY, 9'd0, 9'd255, 12'd4095, 12'd4095, 13'd4096, 13'd4096);
    c_neg = mk_cfg(OP_ADD_GREY, 9'd0, 9'h100, 12'd0, 12'd0, 13'd4096, 13'd4096);
    c_neg1 = mk_cfg(OP_ADD_GREY, 9'd0, 9'h101, 12'd0, 12'd0, 13'd4096, 13'd4096);
    c_mid = mk_cfg(OP_ADD_GREY, 9'd200, 9'd37, 12'd100, 12'd200, 13'd50, 13'd60);
    c_empty = mk_cfg(OP_ADD_GREY, 9'd0, 9'd100, 12'd0, 12'd0, 13'd4096, 13'd0);

    add_row(CFG_AT_RESET, 0, 0, 200, 10, 20, 1, {8'd200, 8'd10, 8'd20, 1'b0});
    add_row(CFG_AT_RESET, 4095, 4095, 255, 255, 255, 1, {8'd255, 8'd255, 8'd255, 1'b0});
    add_row(c_box, 10, 20, 128, 1, 2, 1, {8'd255, 8'd255, 8'd255, 1'b1});
    add_row(c_box, 14, 25, 127, 200, 200, 1, {8'd0, 8'd0, 8'd0, 1'b1});
    add_row(c_box, 15, 25, 50, 60, 70, 1, {8'd50, 8'd60, 8'd70, 1'b0});
    add_row(c_box, 9, 20, 50, 60, 70, 1, {8'd50, 8'd60, 8'd70, 1'b0});
    add_row(c_box, 12, 26, 1, 2, 3, 1, {8'd1, 8'd2, 8'd3, 1'b0});
    add_row(c_box, 12, 19, 4, 5, 6, 1, {8'd4, 8'd5, 8'd6, 1'b0});
    add_row(c_hi, 4095, 4095, 255, 255, 255, 1, {8'd0, 8'd0, 8'd0, 1'b1});
    add_row(c_zero, 0, 0, 0, 0, 0, 1, {8'd255, 8'd255, 8'd255, 1'b1});
    add_row(c_zero, 4095, 0, 0, 7, 9, 1, {8'd255, 8'd255, 8'd255, 1'b1});
    add_row(c_edge, 4095, 4095, 0, 1, 128, 1, {8'd255, 8'd255, 8'd255, 1'b1});
    add_row(c_edge, 4094, 4095, 9, 8, 7, 1, {8'd9, 8'd8, 8'd7, 1'b0});
    add_row(c_edge, 4095, 4094, 9, 8, 7, 1, {8'd9, 8'd8, 8'd7, 1'b0});
    add_row(c_neg, 100, 200, 255, 0, 128, 1, {8'd0, 8'd0, 8'd0, 1'b1});
    add_row(c_neg1, 1, 2, 255, 254, 0, 1, {8'd0, 8'd0, 8'd0, 1'b1});
    add_row(c_mid, 100, 200, 200, 230, 10, 0, '0);
    add_row(c_mid, 149, 259, 0, 218, 255, 0, '0);
    add_row(c_mid, 150, 200, 1, 2, 3, 0, '0);
    add_row(c_mid, 120, 230, 90, 180, 250, 0, '0);
    add_row(c_empty, 5, 5, 1, 2, 3, 1, {8'd1, 8'd2, 8'd3, 1'b0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].cfg != cur)
        program_raw({12'd0, stim_rows[i].cfg.mode},
                    CFG_DATA_BITS'(stim_rows[i].cfg.thr),
                    CFG_DATA_BITS'(stim_rows[i].cfg.ofs),
                    CFG_DATA_BITS'(stim_rows[i].cfg.top),
                    CFG_DATA_BITS'(stim_rows[i].cfg.left),
                    stim_rows[i].cfg.height, stim_rows[i].cfg.width);
      send_word(stim_rows[i].row, stim_rows[i].col, stim_rows[i].red, stim_rows[i].green,
                stim_rows[i].blue, stim_rows[i].typed, stim_rows[i].res, 0);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_raw(CFG_DATA_BITS'(OP_BINARIZE), 0, 0, 0, 0, 4096, 4096);
        1: program_raw(CFG_DATA_BITS'(OP_ADD_GREY), 128, 255, 4095, 4095, 4096, 4096);
        2: program_raw(CFG_DATA_BITS'(OP_ADD_GREY), 128, 13'h0100, 0, 0, 13'h1FFF, 13'h1FFF);
        3: program_raw(13'h1FFE, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1000, 13'h1FFF, 13'h1FFF);
        default:
          program_raw(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                      CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                      CFG_DATA_BITS'($urandom),
                      CFG_DATA_BITS'($urandom_range(3) == 0 ? $urandom : $urandom_range(300)),
                      CFG_DATA_BITS'($urandom_range(3) == 0 ? $urandom : $urandom_range(300)));
      endcase
      case (p % 3)
        0: pct = 0;
        1: pct = 85;
        default: pct = 21;
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        idle_pct = (k % 50 < 10) ? 0 : pct;
        send_word(pick_coord(cur.top, cur.height), pick_coord(cur.left, cur.width),
                  pick_red(cur.thr), pick_chan(), pick_chan(), 0, '0, idle_pct);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d pixels under %0d register settings, %0d of them inside the region.",
             n_pixels, n_settings, n_inside);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words outstanding", pending_pixels.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rmpo_pkg.sv
rtl/rmpo_lane.sv
rtl/rmpo_region.sv
rtl/roi_masked_point_operation.sv
sim/roi_masked_point_operation_tb.sv
